// ===== rtl/core/ppl_pkg.sv =====
// shared types, constants and helpers for the phong pixel lighting pipeline
`timescale 1ns / 1ps
package ppl_pkg;

  localparam int REG_W     = 48;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_ROW_0    = 3'd0,
    REG_NORMAL_ROW_1    = 3'd1,
    REG_NORMAL_ROW_2    = 3'd2,
    REG_LIGHT_DIRECTION = 3'd3,
    REG_CAMERA_POSITION = 3'd4
  } cfg_reg_t;

  localparam logic [REG_W-1:0] RST_NORMAL_ROW_0    = 48'h1000_0000_0000;
  localparam logic [REG_W-1:0] RST_NORMAL_ROW_1    = 48'h0000_1000_0000;
  localparam logic [REG_W-1:0] RST_NORMAL_ROW_2    = 48'h0000_0000_1000;
  localparam logic [REG_W-1:0] RST_LIGHT_DIRECTION = 48'h0000_0000_F000;
  localparam logic [REG_W-1:0] RST_CAMERA_POSITION = 48'h0000_0000_0000;

  // normalizer input width and latency
  localparam int NIN_W    = 28;
  localparam int NORM_LAT = 54;
  // accept edge to the edge that takes the result
  localparam int PIPE_LAT = NORM_LAT + 18;

  localparam logic [15:0] AMBIENT_Q14    = 16'd1638;
  localparam logic [13:0] SPEC_SCALE_Q14 = 14'd9830;
  localparam logic [14:0] ONE_Q14        = 15'd16384;
  localparam logic [19:0] RECIP_510      = 20'd526344;
  localparam int          RECIP_SHIFT    = 28;
  localparam logic [9:0]  DIV_510        = 10'd510;

  typedef logic [2:0][NIN_W-1:0] nvec_in_t;
  typedef logic [2:0][15:0]      nvec_t;

  typedef struct packed {
    logic [7:0]         normal_texel_x;
    logic [7:0]         normal_texel_y;
    logic [7:0]         normal_texel_z;
    logic [7:0]         diffuse_red;
    logic [7:0]         diffuse_green;
    logic [7:0]         diffuse_blue;
    logic [7:0]         specular_red;
    logic [7:0]         specular_green;
    logic [7:0]         specular_blue;
    logic signed [15:0] position_x;
    logic signed [15:0] position_y;
    logic signed [15:0] position_z;
  } in_item_t;

  typedef struct packed {
    logic [15:0] color_red;
    logic [15:0] color_green;
    logic [15:0] color_blue;
  } out_item_t;

  // round to nearest by 2^14, ties away from zero
  function automatic logic signed [39:0] round_q14(input logic signed [39:0] v);
    logic [39:0] mag;
    logic [39:0] r;
    mag = v[39] ? (~v + 40'd1) : v;
    r   = (mag + 40'd8192) >> 14;
    return v[39] ? $signed(~r + 40'd1) : $signed(r);
  endfunction

endpackage

// ===== rtl/core/ppl_norm.sv =====
// pipelined 3-vector normalizer to q2.14 (shift, sum of squares, isqrt, divide)
`timescale 1ns / 1ps
module ppl_norm
  import ppl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  nvec_in_t in_vec,
  output logic     out_valid,
  output nvec_t    out_vec
);

  localparam int W_W       = 30;
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 15;
  localparam int NUM_W     = 47;
  localparam int LEN_W     = 31;

  typedef struct packed {
    logic [2:0][W_W-1:0] w;
    logic [2:0]          sgn;
    logic                zero;
  } ncar_t;

  logic [NORM_LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NORM_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[NORM_LAT-1];

  // stage a: magnitudes
  logic [2:0][NIN_W-1:0] mag_a_r, mag_a_nxt;
  logic [2:0]            sgn_a_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_a_nxt[i] = in_vec[i][NIN_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
    end
  end

  always_ff @(posedge clk) begin
    mag_a_r <= mag_a_nxt;
    for (int i = 0; i < 3; i++) begin
      sgn_a_r[i] <= in_vec[i][NIN_W-1];
    end
  end

  // stage b: shift count from the top set bit
  logic [4:0]            sh_b_r, sh_b_nxt;
  logic                  zero_b_r, zero_b_nxt;
  logic [2:0][NIN_W-1:0] mag_b_r;
  logic [2:0]            sgn_b_r;
  logic [W_W-1:0]        any_bits;
  logic [4:0]            top_bit;

  always_comb begin
    any_bits = W_W'(mag_a_r[0] | mag_a_r[1] | mag_a_r[2]);
    top_bit  = '0;
    for (int b = 0; b < W_W; b++) begin
      if (any_bits[b]) begin
        top_bit = 5'(b);
      end
    end
    sh_b_nxt   = 5'(W_W - 1) - top_bit;
    zero_b_nxt = (any_bits == '0);
  end

  always_ff @(posedge clk) begin
    sh_b_r   <= sh_b_nxt;
    zero_b_r <= zero_b_nxt;
    mag_b_r  <= mag_a_r;
    sgn_b_r  <= sgn_a_r;
  end

  // stage c: shift up
  ncar_t car_c_r, car_c_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      car_c_nxt.w[i] = W_W'(mag_b_r[i]) << sh_b_r;
    end
    car_c_nxt.sgn  = sgn_b_r;
    car_c_nxt.zero = zero_b_r;
  end

  always_ff @(posedge clk) begin
    car_c_r <= car_c_nxt;
  end

  // stage d: squares
  logic [2:0][2*W_W-1:0] sq_d_r;
  ncar_t                 car_d_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_d_r[i] <= car_c_r.w[i] * car_c_r.w[i];
    end
    car_d_r <= car_c_r;
  end

  // stage e: sum of squares
  logic [61:0] len2_e_r;
  ncar_t       car_e_r;

  always_ff @(posedge clk) begin
    len2_e_r <= 62'(sq_d_r[0]) + 62'(sq_d_r[1]) + 62'(sq_d_r[2]);
    car_e_r  <= car_d_r;
  end

  // integer square root, one result bit per stage
  logic [63:0] sx_r   [SQ_STEPS];
  logic [63:0] sres_r [SQ_STEPS];
  ncar_t       scar_r [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [63:0] x_in, res_in, bit_v, trial, x_nxt, res_nxt;
    ncar_t       car_in;

    if (k == 0) begin : g_first
      assign x_in   = 64'(len2_e_r);
      assign res_in = '0;
      assign car_in = car_e_r;
    end else begin : g_next
      assign x_in   = sx_r[k-1];
      assign res_in = sres_r[k-1];
      assign car_in = scar_r[k-1];
    end

    always_comb begin
      bit_v = 64'd1 << (62 - 2 * k);
      trial = res_in + bit_v;
      if (x_in >= trial) begin
        x_nxt   = x_in - trial;
        res_nxt = (res_in >> 1) + bit_v;
      end else begin
        x_nxt   = x_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      sx_r[k]   <= x_nxt;
      sres_r[k] <= res_nxt;
      scar_r[k] <= car_in;
    end
  end

  // stage f: numerator and divisor for round(w * 2^14 / len)
  logic [LEN_W-1:0]        len_f;
  logic [2:0][NUM_W-1:0]   num_f_r;
  logic [NUM_W-1:0]        den_f_r;
  ncar_t                   car_f_r;

  assign len_f = sres_r[SQ_STEPS-1][LEN_W-1:0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      num_f_r[i] <= (NUM_W'(scar_r[SQ_STEPS-1].w[i]) << 15) + NUM_W'(len_f);
    end
    den_f_r <= NUM_W'(len_f) << 1;
    car_f_r <= scar_r[SQ_STEPS-1];
  end

  // restoring divide, one quotient bit per stage
  logic [2:0][NUM_W-1:0]     drem_r [DIV_STEPS];
  logic [2:0][DIV_STEPS-1:0] dq_r   [DIV_STEPS];
  logic [NUM_W-1:0]          dden_r [DIV_STEPS];
  logic [2:0]                dsgn_r [DIV_STEPS];
  logic                      dzero_r[DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [2:0][NUM_W-1:0]     rem_in, rem_nxt;
    logic [2:0][DIV_STEPS-1:0] q_in, q_nxt;
    logic [NUM_W-1:0]          den_in, trial;
    logic [2:0]                sgn_in;
    logic                      zero_in;

    if (j == 0) begin : g_first
      assign rem_in  = num_f_r;
      assign q_in    = '0;
      assign den_in  = den_f_r;
      assign sgn_in  = car_f_r.sgn;
      assign zero_in = car_f_r.zero;
    end else begin : g_next
      assign rem_in  = drem_r[j-1];
      assign q_in    = dq_r[j-1];
      assign den_in  = dden_r[j-1];
      assign sgn_in  = dsgn_r[j-1];
      assign zero_in = dzero_r[j-1];
    end

    always_comb begin
      trial = den_in << (DIV_STEPS - 1 - j);
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= trial) begin
          rem_nxt[i] = rem_in[i] - trial;
          q_nxt[i]   = q_in[i] | (DIV_STEPS'(1) << (DIV_STEPS - 1 - j));
        end else begin
          rem_nxt[i] = rem_in[i];
          q_nxt[i]   = q_in[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      drem_r[j]  <= rem_nxt;
      dq_r[j]    <= q_nxt;
      dden_r[j]  <= den_in;
      dsgn_r[j]  <= sgn_in;
      dzero_r[j] <= zero_in;
    end
  end

  // stage g: sign and zero vector
  nvec_t out_vec_r, out_vec_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dzero_r[DIV_STEPS-1]) begin
        out_vec_nxt[i] = '0;
      end else if (dsgn_r[DIV_STEPS-1][i]) begin
        out_vec_nxt[i] = ~{1'b0, dq_r[DIV_STEPS-1][i]} + 16'd1;
      end else begin
        out_vec_nxt[i] = {1'b0, dq_r[DIV_STEPS-1][i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    out_vec_r <= out_vec_nxt;
  end

  assign out_vec = out_vec_r;

endmodule

// ===== rtl/core/phong_pixel_lighting_top.sv =====
// top level of the per-pixel phong lighting pipeline
`timescale 1ns / 1ps
// Fully pipelined: one fragment is taken on every clock (busy stays low) and
// its color comes out on out_strobe for one cycle, in order. The latency is
// set by the three normalizers (32-step square root and 15-step divide)
// followed by the dot product, power-of-16 and texel scaling stages. The
// receiver cannot stall, so a result must be taken in the cycle it is shown.
// Registers are written through cfg_we/cfg_index/cfg_data with no wait;
// write them only while no fragment is in flight.
module phong_pixel_lighting_top
  import ppl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output logic                 out_strobe,
  output out_item_t            out_item
);

  localparam int TEX_DLY = NORM_LAT + 11;
  localparam int DF_DLY  = 9;
  localparam int P_STAGES = 15;

  assign busy = 1'b0;

  // configuration registers
  logic [REG_W-1:0] row_r [3];
  logic [REG_W-1:0] light_r;
  logic [REG_W-1:0] cam_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= RST_NORMAL_ROW_0;
      row_r[1] <= RST_NORMAL_ROW_1;
      row_r[2] <= RST_NORMAL_ROW_2;
      light_r  <= RST_LIGHT_DIRECTION;
      cam_r    <= RST_CAMERA_POSITION;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_NORMAL_ROW_0:    row_r[0] <= cfg_data;
        REG_NORMAL_ROW_1:    row_r[1] <= cfg_data;
        REG_NORMAL_ROW_2:    row_r[2] <= cfg_data;
        REG_LIGHT_DIRECTION: light_r  <= cfg_data;
        REG_CAMERA_POSITION: cam_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // t0: capture
  in_item_t in_r;
  logic     t0_vld_r, t1_vld_r, t2_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_vld_r <= 1'b0;
      t1_vld_r <= 1'b0;
      t2_vld_r <= 1'b0;
    end else begin
      t0_vld_r <= start && !busy;
      t1_vld_r <= t0_vld_r;
      t2_vld_r <= t1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_item;
  end

  // t1: decode normal texels and matrix products, view offset
  logic signed [9:0]  dec [3];
  logic [2:0][7:0]    ntex;
  logic [2:0][15:0]   pos;
  logic signed [25:0] mp_r   [3][3];
  logic signed [16:0] diff_r [3];
  logic [5:0][7:0]    tex_t1_r, tex_t2_r;

  always_comb begin
    ntex = {in_r.normal_texel_z, in_r.normal_texel_y, in_r.normal_texel_x};
    pos  = {in_r.position_z, in_r.position_y, in_r.position_x};
    for (int k = 0; k < 3; k++) begin
      dec[k] = $signed({1'b0, ntex[k], 1'b0}) - 10'sd255;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        mp_r[i][k] <= $signed(row_r[i][47-16*k -: 16]) * dec[k];
      end
      diff_r[i] <= 17'($signed(pos[i])) - 17'($signed(cam_r[47-16*i -: 16]));
    end
    tex_t1_r <= {in_r.specular_blue, in_r.specular_green, in_r.specular_red,
                 in_r.diffuse_blue, in_r.diffuse_green, in_r.diffuse_red};
    tex_t2_r <= tex_t1_r;
  end

  // t2: matrix sums
  nvec_in_t v_t2_r, view_t2_r;
  nvec_in_t light_vec;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      v_t2_r[i]    <= NIN_W'(mp_r[i][0]) + NIN_W'(mp_r[i][1]) + NIN_W'(mp_r[i][2]);
      view_t2_r[i] <= NIN_W'(diff_r[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      light_vec[i] = NIN_W'($signed(light_r[47-16*i -: 16]));
    end
  end

  // normalizers
  nvec_t n_vec, l_vec, vd_vec;
  logic  n_vld, l_vld, vd_vld;

  ppl_norm u_norm_n (
    .clk(clk), .rst_n(rst_n), .in_valid(t2_vld_r), .in_vec(v_t2_r),
    .out_valid(n_vld), .out_vec(n_vec)
  );

  ppl_norm u_norm_l (
    .clk(clk), .rst_n(rst_n), .in_valid(t2_vld_r), .in_vec(light_vec),
    .out_valid(l_vld), .out_vec(l_vec)
  );

  ppl_norm u_norm_v (
    .clk(clk), .rst_n(rst_n), .in_valid(t2_vld_r), .in_vec(view_t2_r),
    .out_valid(vd_vld), .out_vec(vd_vec)
  );

  // texel and diffuse factor delay lines
  logic [5:0][7:0] tex_line_r [TEX_DLY];
  logic [16:0]     df_line_r  [DF_DLY];
  logic [P_STAGES-1:0] p_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= '0;
    end else begin
      p_vld_r <= {p_vld_r[P_STAGES-2:0], n_vld && l_vld && vd_vld};
    end
  end

  // p1: l.n products
  logic signed [31:0] ln_r [3];
  nvec_t n1_r, l1_r, vd1_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ln_r[i] <= $signed(l_vec[i]) * $signed(n_vec[i]);
    end
    n1_r  <= n_vec;
    l1_r  <= l_vec;
    vd1_r <= vd_vec;
  end

  // p2: dot, diffuse factor
  logic signed [39:0] dl_full;
  logic signed [17:0] dl_r;
  logic [16:0]        df_r;
  nvec_t n2_r, l2_r, vd2_r;

  assign dl_full = round_q14(40'(ln_r[0]) + 40'(ln_r[1]) + 40'(ln_r[2]));

  always_ff @(posedge clk) begin
    dl_r  <= 18'(dl_full);
    df_r  <= dl_full[39] ? 17'(-dl_full) : '0;
    n2_r  <= n1_r;
    l2_r  <= l1_r;
    vd2_r <= vd1_r;
  end

  // p3: 2*dl*n
  logic signed [34:0] m2_r [3];
  nvec_t l3_r, vd3_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      m2_r[i] <= $signed({dl_r, 1'b0}) * $signed(n2_r[i]);
    end
    l3_r  <= l2_r;
    vd3_r <= vd2_r;
  end

  // p4: reflected ray
  logic signed [21:0] r4_r [3];
  nvec_t vd4_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      r4_r[i] <= 22'(round_q14(40'(m2_r[i])) - 40'($signed(l3_r[i])));
    end
    vd4_r <= vd3_r;
  end

  // p5: r.v products
  logic signed [37:0] rv_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      rv_r[i] <= r4_r[i] * $signed(vd4_r[i]);
    end
  end

  // p6: closeness, clamped to one
  logic signed [39:0] cl_full;
  logic [39:0]        cl_mag;
  logic [14:0]        c6_r;

  always_comb begin
    cl_full = round_q14(40'(rv_r[0]) + 40'(rv_r[1]) + 40'(rv_r[2]));
    cl_mag  = cl_full[39] ? 40'(-cl_full) : '0;
  end

  always_ff @(posedge clk) begin
    c6_r <= (cl_mag > 40'(ONE_Q14)) ? ONE_Q14 : 15'(cl_mag);
  end

  // p7..p10: four rounded squarings
  logic [14:0] csq_r [4];

  always_ff @(posedge clk) begin
    csq_r[0] <= 15'((31'(c6_r) * 31'(c6_r) + 31'd8192) >> 14);
    for (int k = 1; k < 4; k++) begin
      csq_r[k] <= 15'((31'(csq_r[k-1]) * 31'(csq_r[k-1]) + 31'd8192) >> 14);
    end
  end

  // p11: specular scale
  logic [14:0] sf_r;

  always_ff @(posedge clk) begin
    sf_r <= 15'((29'(csq_r[3]) * 29'(SPEC_SCALE_Q14) + 29'd8192) >> 14);
  end

  always_ff @(posedge clk) begin
    tex_line_r[0] <= tex_t2_r;
    for (int k = 1; k < TEX_DLY; k++) begin
      tex_line_r[k] <= tex_line_r[k-1];
    end
    df_line_r[0] <= df_r;
    for (int k = 1; k < DF_DLY; k++) begin
      df_line_r[k] <= df_line_r[k-1];
    end
  end

  // p12: 2*t*f + 255 per channel, diffuse and specular
  logic [26:0] x12_r [3][2];
  logic [5:0][7:0] tex_p11;

  assign tex_p11 = tex_line_r[TEX_DLY-1];

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      x12_r[ch][0] <= ((27'(tex_p11[ch]) * 27'(df_line_r[DF_DLY-1])) << 1) + 27'd255;
      x12_r[ch][1] <= ((27'(tex_p11[ch+3]) * 27'(sf_r)) << 1) + 27'd255;
    end
  end

  // p13: reciprocal multiply for /510
  logic [46:0] pm13_r [3][2];
  logic [26:0] x13_r  [3][2];

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int s = 0; s < 2; s++) begin
        pm13_r[ch][s] <= 47'(x12_r[ch][s]) * 47'(RECIP_510);
        x13_r[ch][s]  <= x12_r[ch][s];
      end
    end
  end

  // p14: quotient correction, estimate is low by at most one
  logic [18:0] q0   [3][2];
  logic [26:0] rem0 [3][2];
  logic [18:0] q14_r [3][2];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int s = 0; s < 2; s++) begin
        q0[ch][s]   = 19'(pm13_r[ch][s] >> RECIP_SHIFT);
        rem0[ch][s] = x13_r[ch][s] - 27'(q0[ch][s]) * 27'(DIV_510);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int s = 0; s < 2; s++) begin
        q14_r[ch][s] <= (rem0[ch][s] >= 27'(DIV_510)) ? q0[ch][s] + 19'd1 : q0[ch][s];
      end
    end
  end

  // p15: ambient plus terms, saturate
  logic [20:0]      sum15 [3];
  logic [2:0][15:0] col_nxt;
  out_item_t        out_item_r;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum15[ch]   = 21'(AMBIENT_Q14) + 21'(q14_r[ch][0]) + 21'(q14_r[ch][1]);
      col_nxt[ch] = (sum15[ch] > 21'hFFFF) ? 16'hFFFF : 16'(sum15[ch]);
    end
  end

  always_ff @(posedge clk) begin
    out_item_r.color_red   <= col_nxt[0];
    out_item_r.color_green <= col_nxt[1];
    out_item_r.color_blue  <= col_nxt[2];
  end

  assign out_item   = out_item_r;
  assign out_strobe = p_vld_r[P_STAGES-1];

endmodule

// ===== rtl/core/ppl_checker.sv =====
// port-level checker for the lighting pipeline and its bind
`timescale 1ns / 1ps
module ppl_checker
  import ppl_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      cfg_we,
  input logic      out_strobe,
  input out_item_t out_item
);

  // every accepted item comes out after the fixed latency
  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_strobe)
    else $error("accepted item produced no result");

  // no result without an item accepted that long ago
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, PIPE_LAT))
    else $error("result without an accepted item");

  // ambient is always added
  a_ambient: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.color_red >= AMBIENT_Q14 &&
                    out_item.color_green >= AMBIENT_Q14 &&
                    out_item.color_blue >= AMBIENT_Q14))
    else $error("color below ambient");

  // no config write sampled just before a result is shown
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !$past(cfg_we, 1))
    else $error("config written during an item");

endmodule

bind phong_pixel_lighting_top ppl_checker u_ppl_checker (.*);

// ===== sim/testbench.sv =====
// self-checking testbench for the phong pixel lighting pipeline
`timescale 1ns / 1ps
module testbench
  import ppl_pkg::*;
;

  localparam int  NUM_REGS    = 5;
  localparam int  TIMEOUT_CYC = 300000;
  localparam int  DRAIN_CYC   = PIPE_LAT + 20;
  localparam int  RAND_PHASES = 5;
  localparam int  PHASE_ITEMS = 90;
  localparam logic [REG_W-1:0] ROW0_INIT  = 48'h1000_0000_0000;
  localparam logic [REG_W-1:0] ROW1_INIT  = 48'h0000_1000_0000;
  localparam logic [REG_W-1:0] ROW2_INIT  = 48'h0000_0000_1000;
  localparam logic [REG_W-1:0] LIGHT_INIT = 48'h0000_0000_F000;
  localparam logic [REG_W-1:0] CAM_INIT   = 48'h0000_0000_0000;

  class lighting_scoreboard;
    logic [REG_W-1:0] regs [NUM_REGS];
    out_item_t        color_q[$];
    int               errors;

    function new();
      regs[REG_NORMAL_ROW_0]    = ROW0_INIT;
      regs[REG_NORMAL_ROW_1]    = ROW1_INIT;
      regs[REG_NORMAL_ROW_2]    = ROW2_INIT;
      regs[REG_LIGHT_DIRECTION] = LIGHT_INIT;
      regs[REG_CAMERA_POSITION] = CAM_INIT;
      errors = 0;
    endfunction

    function void write_reg(int idx, logic [REG_W-1:0] data);
      if (idx < NUM_REGS) regs[idx] = data;
    endfunction

    function longint entry(logic [REG_W-1:0] r, int k);
      logic signed [15:0] e;
      e = r[32-16*k +: 16];
      return longint'(e);
    endfunction

    function longint round14(longint x);
      longint m;
      m = x < 0 ? -x : x;
      m = (m + 8192) >> 14;
      return x < 0 ? -m : m;
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void unit_vec(input longint v[3], output longint o[3]);
      longint unsigned m, len2, len, q;
      longint unsigned w[3];
      m = 0;
      len2 = 0;
      for (int i = 0; i < 3; i++) begin
        w[i] = v[i] < 0 ? -v[i] : v[i];
        if (w[i] > m) m = w[i];
      end
      if (m == 0) begin
        for (int i = 0; i < 3; i++) o[i] = 0;
        return;
      end
      while (m < (64'd1 << 29)) begin
        for (int i = 0; i < 3; i++) w[i] = w[i] << 1;
        m = m << 1;
      end
      for (int i = 0; i < 3; i++) len2 += w[i] * w[i];
      len = int_sqrt(len2);
      for (int i = 0; i < 3; i++) begin
        q = ((w[i] << 15) + len) / (2 * len);
        o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
    endfunction

    function longint dot14(longint a[3], longint b[3]);
      return round14(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
    endfunction

    function longint unsigned scale_texel(longint unsigned t, longint unsigned f);
      return (t * f * 2 + 255) / 510;
    endfunction

    function void note_fragment(in_item_t f);
      longint d[3], v[3], n[3], l[3], r[3], vd[3], tmp[3];
      longint dl, cl;
      longint unsigned df, c, sf, sum;
      logic [7:0] dtex[3], stex[3];
      logic signed [15:0] pos[3];
      logic [15:0] col[3];
      out_item_t exp_color;
      d[0] = 2 * longint'(f.normal_texel_x) - 255;
      d[1] = 2 * longint'(f.normal_texel_y) - 255;
      d[2] = 2 * longint'(f.normal_texel_z) - 255;
      for (int i = 0; i < 3; i++) begin
        v[i] = 0;
        for (int k = 0; k < 3; k++) v[i] += entry(regs[i], k) * d[k];
      end
      unit_vec(v, n);
      for (int i = 0; i < 3; i++) tmp[i] = entry(regs[REG_LIGHT_DIRECTION], i);
      unit_vec(tmp, l);
      dl = dot14(l, n);
      df = dl < 0 ? -dl : 0;
      for (int i = 0; i < 3; i++) r[i] = -l[i] + round14(2 * dl * n[i]);
      pos[0] = f.position_x;
      pos[1] = f.position_y;
      pos[2] = f.position_z;
      for (int i = 0; i < 3; i++)
        tmp[i] = longint'(pos[i]) - entry(regs[REG_CAMERA_POSITION], i);
      unit_vec(tmp, vd);
      cl = dot14(r, vd);
      c = cl < 0 ? -cl : 0;
      if (c > 16384) c = 16384;
      repeat (4) c = (c * c + 8192) >> 14;
      sf = (c * 9830 + 8192) >> 14;
      dtex[0] = f.diffuse_red;
      dtex[1] = f.diffuse_green;
      dtex[2] = f.diffuse_blue;
      stex[0] = f.specular_red;
      stex[1] = f.specular_green;
      stex[2] = f.specular_blue;
      for (int i = 0; i < 3; i++) begin
        sum = 1638 + scale_texel(dtex[i], df) + scale_texel(stex[i], sf);
        col[i] = sum > 65535 ? 16'hFFFF : sum[15:0];
      end
      exp_color.color_red   = col[0];
      exp_color.color_green = col[1];
      exp_color.color_blue  = col[2];
      color_q.push_back(exp_color);
    endfunction

    function void check_color(out_item_t got);
      out_item_t exp_color;
      if (color_q.size() == 0) begin
        $display("%0t: unexpected color, actual %h", $time, got);
        errors++;
        return;
      end
      exp_color = color_q.pop_front();
      if (got.color_red !== exp_color.color_red) begin
        $display("%0t: red mismatch, expected %0d actual %0d", $time,
                 exp_color.color_red, got.color_red);
        errors++;
      end
      if (got.color_green !== exp_color.color_green) begin
        $display("%0t: green mismatch, expected %0d actual %0d", $time,
                 exp_color.color_green, got.color_green);
        errors++;
      end
      if (got.color_blue !== exp_color.color_blue) begin
        $display("%0t: blue mismatch, expected %0d actual %0d", $time,
                 exp_color.color_blue, got.color_blue);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;
  logic                 out_strobe;
  out_item_t            out_item;

  lighting_scoreboard sb;
  int unsigned        cycles;
  int                 sent;
  int                 idle_pct;

  phong_pixel_lighting_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYC) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_color(out_item);
  end

  // cfg_we is left high; the caller lowers it after the last write
  task automatic cfg_write(int idx, logic [REG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic send_fragment(in_item_t f);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= f;
    do @(posedge clk); while (busy);
    sb.note_fragment(f);
    sent++;
    if (sent == 150) idle_pct = 78;
    if (sent == 300) idle_pct = 0;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.color_q.size() != 0) @(posedge clk);
  endtask

  function automatic in_item_t rand_fragment();
    in_item_t    f;
    logic [127:0] rbits;
    rbits = {$urandom, $urandom, $urandom, $urandom};
    f = rbits[$bits(in_item_t)-1:0];
    case ($urandom_range(9))
      0: begin
        // fragment sits at the camera
        f.position_x = sb.regs[REG_CAMERA_POSITION][47:32];
        f.position_y = sb.regs[REG_CAMERA_POSITION][31:16];
        f.position_z = sb.regs[REG_CAMERA_POSITION][15:0];
      end
      1: begin
        f.normal_texel_x = 8'($urandom_range(127, 128));
        f.normal_texel_y = 8'($urandom_range(127, 128));
        f.normal_texel_z = $urandom_range(1) ? 8'd255 : 8'd0;
      end
      default: ;
    endcase
    return f;
  endfunction

  function automatic logic [REG_W-1:0] rand_row();
    logic [15:0] e[3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(3))
        0: e[i] = 16'($urandom);
        1: e[i] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        2: e[i] = 16'h0000;
        default: e[i] = 16'($urandom_range(8192)) - 16'd4096;
      endcase
    end
    return {e[0], e[1], e[2]};
  endfunction

  function automatic in_item_t make_fragment(logic [7:0] nx, logic [7:0] ny, logic [7:0] nz,
                                             logic [7:0] dc, logic [7:0] sc,
                                             logic [15:0] px, logic [15:0] py,
                                             logic [15:0] pz);
    in_item_t f;
    f.normal_texel_x = nx;
    f.normal_texel_y = ny;
    f.normal_texel_z = nz;
    f.diffuse_red    = dc;
    f.diffuse_green  = dc;
    f.diffuse_blue   = dc;
    f.specular_red   = sc;
    f.specular_green = sc;
    f.specular_blue  = sc;
    f.position_x     = px;
    f.position_y     = py;
    f.position_z     = pz;
    return f;
  endfunction

  initial begin
    logic [REG_W-1:0] cfg_set [NUM_REGS];
    sb        = new();
    cycles    = 0;
    sent      = 0;
    idle_pct  = 11;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items at the reset setting
    send_fragment(make_fragment(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000));
    send_fragment(make_fragment(8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                                16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_fragment(make_fragment(8'd128, 8'd128, 8'd255, 8'd255, 8'd255,
                                16'h0000, 16'h0000, 16'h0100));
    send_fragment(make_fragment(8'd127, 8'd127, 8'd0, 8'd255, 8'd255,
                                16'h0000, 16'h0000, 16'h8000));
    send_fragment(make_fragment(8'd128, 8'd128, 8'd255, 8'd200, 8'd255,
                                16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_fragment(make_fragment(8'd127, 8'd128, 8'd0, 8'd255, 8'd255,
                                16'h8000, 16'h8000, 16'h8000));
    send_fragment(make_fragment(8'd0, 8'd255, 8'd128, 8'd17, 8'd240,
                                16'h0001, 16'hFFFF, 16'h0000));
    send_fragment(make_fragment(8'd128, 8'd128, 8'd0, 8'd255, 8'd255,
                                16'h0000, 16'h0000, 16'hFF00));
    drain();

    // zero matrix, zero light, fragment at the camera, ignored indexes
    cfg_write(REG_NORMAL_ROW_0, '0);
    cfg_write(REG_NORMAL_ROW_1, '0);
    cfg_write(REG_NORMAL_ROW_2, '0);
    cfg_write(NUM_REGS, 48'hFFFF_FFFF_FFFF);
    cfg_write(NUM_REGS + 2, 48'h1234_5678_9ABC);
    cfg_write(REG_CAMERA_POSITION, 48'h0100_FF00_7FFF);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_fragment(make_fragment(8'd200, 8'd10, 8'd90, 8'd255, 8'd255,
                                16'h0000, 16'h0000, 16'h0000));
    send_fragment(make_fragment(8'd255, 8'd0, 8'd255, 8'd255, 8'd255,
                                16'h0100, 16'hFF00, 16'h7FFF));
    drain();
    cfg_write(REG_LIGHT_DIRECTION, '0);
    cfg_we <= 1'b0;
    send_fragment(make_fragment(8'd255, 8'd0, 8'd255, 8'd255, 8'd255,
                                16'h0000, 16'h0000, 16'h0000));
    drain();
    cfg_write(REG_NORMAL_ROW_0, 48'h7FFF_7FFF_7FFF);
    cfg_write(REG_NORMAL_ROW_1, 48'h8000_8000_8000);
    cfg_write(REG_NORMAL_ROW_2, 48'h7FFF_8000_7FFF);
    cfg_write(REG_LIGHT_DIRECTION, 48'h8000_7FFF_8000);
    cfg_write(REG_CAMERA_POSITION, 48'h8000_8000_8000);
    cfg_we <= 1'b0;
    send_fragment(make_fragment(8'd0, 8'd0, 8'd0, 8'd255, 8'd255,
                                16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_fragment(make_fragment(8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                                16'h8000, 16'h8000, 16'h8000));
    send_fragment(make_fragment(8'd255, 8'd0, 8'd128, 8'd255, 8'd255,
                                16'h0000, 16'h0000, 16'h0000));
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_set[i] = rand_row();
      if (p == 0) begin
        // mostly the reset setting with a tilted light
        cfg_set[REG_NORMAL_ROW_0]    = ROW0_INIT;
        cfg_set[REG_NORMAL_ROW_1]    = ROW1_INIT;
        cfg_set[REG_NORMAL_ROW_2]    = ROW2_INIT;
        cfg_set[REG_LIGHT_DIRECTION] = 48'h0800_F800_F000;
      end
      for (int i = 0; i < NUM_REGS; i++) cfg_write(i, cfg_set[i]);
      cfg_write(NUM_REGS + 1, 48'({$urandom, $urandom}));
      cfg_we <= 1'b0;
      for (int k = 0; k < PHASE_ITEMS; k++) send_fragment(rand_fragment());
      drain();
    end

    repeat (DRAIN_CYC) @(posedge clk);
    if (sb.errors == 0 && sb.color_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
